// ----- rtl/fss_pkg.sv -----
// Shared types, constants and helpers for the firmware signature scanner.
package fss_pkg;

  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned RES_BITS    = 32;
  localparam int unsigned EXT_BITS    = (OFFSET_BITS > RES_BITS) ? OFFSET_BITS : RES_BITS;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned HIST_LEN    = 12;
  localparam int unsigned WIN_LEN     = HIST_LEN + 1;
  localparam int unsigned WIN_BITS    = WIN_LEN * BYTE_BITS;
  localparam int unsigned NUM_SIGS    = 4;
  localparam int unsigned LAG_BITS    = 4;

  localparam logic [CFG_BITS-1:0] MIN_LENGTH_RESET = 16'd512;

  typedef enum logic [1:0] {
    SIG_LOADER  = 2'd0,
    SIG_KERNEL  = 2'd1,
    SIG_SQUASH  = 2'd2,
    SIG_FLASHFS = 2'd3
  } sig_idx_t;

  // signature lengths in bytes
  localparam logic [LAG_BITS-1:0] SIG_LEN [NUM_SIGS] = '{4'd6, 4'd13, 4'd4, 4'd2};

  // patterns right-aligned in the window: newest byte in the low bits
  localparam logic [WIN_BITS-1:0] PAT_LOADER  = WIN_BITS'(48'h552D426F6F74);
  localparam logic [WIN_BITS-1:0] PAT_KERNEL  = WIN_BITS'(104'h4C696E75782076657273696F6E);
  localparam logic [WIN_BITS-1:0] PAT_SQ_A    = WIN_BITS'(32'h73717368);
  localparam logic [WIN_BITS-1:0] PAT_SQ_B    = WIN_BITS'(32'h68737173);
  localparam logic [WIN_BITS-1:0] PAT_FLASHFS = WIN_BITS'(16'h1985);

  typedef struct packed {
    logic step;   // word accepted, not the last of the image
    logic flush;  // last word of the image accepted
  } scan_ctl_t;

  typedef struct packed {
    logic                too_small;
    logic                any_found;
    logic [NUM_SIGS-1:0] found;
    logic [RES_BITS-1:0] loader_offset;
    logic [RES_BITS-1:0] kernel_offset;
    logic [RES_BITS-1:0] squash_offset;
    logic [RES_BITS-1:0] flashfs_offset;
  } res_t;

  function automatic logic [WIN_BITS-1:0] sig_mask(input logic [LAG_BITS-1:0] len);
    sig_mask = {WIN_BITS{1'b1}} >> (WIN_BITS - BYTE_BITS * int'(len));
  endfunction

  function automatic logic sig_hit(input logic [WIN_BITS-1:0] win,
                                   input logic [WIN_BITS-1:0] pat,
                                   input logic [LAG_BITS-1:0] len);
    sig_hit = ((win ^ pat) & sig_mask(len)) == '0;
  endfunction

endpackage

// ----- rtl/fss_if.sv -----
// Word channels of the scanner: image bytes in, scan results out.
interface fss_in_if;
  logic                          valid;
  logic                          ready;
  logic [fss_pkg::BYTE_BITS-1:0] data_byte;
  logic                          is_last;

  modport source (output valid, data_byte, is_last, input ready);
  modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface fss_out_if;
  logic                         valid;
  logic                         ready;
  logic                         too_small;
  logic                         any_found;
  logic                         loader_found;
  logic [fss_pkg::RES_BITS-1:0] loader_offset;
  logic                         kernel_found;
  logic [fss_pkg::RES_BITS-1:0] kernel_offset;
  logic                         squash_found;
  logic [fss_pkg::RES_BITS-1:0] squash_offset;
  logic                         flashfs_found;
  logic [fss_pkg::RES_BITS-1:0] flashfs_offset;

  modport source (output valid, too_small, any_found, loader_found, loader_offset,
                  kernel_found, kernel_offset, squash_found, squash_offset,
                  flashfs_found, flashfs_offset, input ready);
  modport sink   (input valid, too_small, any_found, loader_found, loader_offset,
                  kernel_found, kernel_offset, squash_found, squash_offset,
                  flashfs_found, flashfs_offset, output ready);
endinterface

// ----- rtl/fss_cell.sv -----
// One history cell: holds a byte and whether it belongs to the current image.
module fss_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fss_pkg::scan_ctl_t            ctl,
  input  logic [fss_pkg::BYTE_BITS-1:0] data_in,
  input  logic                          live_in,
  output logic [fss_pkg::BYTE_BITS-1:0] data_out,
  output logic                          live_out
);

  logic [fss_pkg::BYTE_BITS-1:0] data_r;
  logic                          live_r;
  logic                          live_nxt;

  always_comb begin
    live_nxt = live_r;
    if (ctl.flush) begin
      live_nxt = 1'b0;
    end else if (ctl.step) begin
      live_nxt = live_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      data_r <= data_in;
    end
  end

  assign data_out = data_r;
  assign live_out = live_r;

endmodule

// ----- rtl/fss_sig_track.sv -----
// First-match tracker for one signature: found flag and start offset.
module fss_sig_track (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fss_pkg::scan_ctl_t              ctl,
  input  logic                            hit,
  input  logic [fss_pkg::LAG_BITS-1:0]    lag,
  input  logic [fss_pkg::OFFSET_BITS-1:0] position,
  output logic                            found_now,
  output logic [fss_pkg::OFFSET_BITS-1:0] offset_now
);

  logic                            found_r;
  logic                            found_nxt;
  logic [fss_pkg::OFFSET_BITS-1:0] offset_r;

  assign found_now  = found_r | hit;
  assign offset_now = found_r ? offset_r : position - fss_pkg::OFFSET_BITS'(lag);

  always_comb begin
    found_nxt = found_r;
    if (ctl.flush) begin
      found_nxt = 1'b0;
    end else if (ctl.step) begin
      found_nxt = found_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      offset_r <= offset_now;
    end
  end

endmodule

// ----- rtl/firmware_signature_scanner.sv -----
// Scanner top level: history cell chain, signature trackers and result register.
//
// Takes one image byte per clock with no gaps of its own. Bytes shift
// through a chain of twelve history cells; the window of those twelve plus
// the incoming byte is compared against the four signatures in the same
// cycle. The result for an image is registered on the cycle its last byte is
// accepted and shown in the next cycle. in_ch.ready drops only while that
// result register is full and out_ch.ready is low. Byte positions saturate at
// 2^OFFSET_BITS - 1. No clearing pass after reset; min_length resets to 512.
module firmware_signature_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fss_pkg::CFG_BITS-1:0] cfg_wdata,
  fss_in_if.sink                       in_ch,
  fss_out_if.source                    out_ch
);

  logic                            in_fire;
  fss_pkg::scan_ctl_t              ctl;
  logic [fss_pkg::CFG_BITS-1:0]    min_len_r;
  logic [fss_pkg::OFFSET_BITS-1:0] pos_r;
  logic [fss_pkg::OFFSET_BITS-1:0] pos_nxt;
  logic                            pos_sat;
  logic                            short_img;

  logic [fss_pkg::BYTE_BITS-1:0]   cell_data [fss_pkg::HIST_LEN];
  logic                            cell_live [fss_pkg::HIST_LEN];
  logic [fss_pkg::WIN_BITS-1:0]    win;

  logic [fss_pkg::NUM_SIGS-1:0]    hit_raw;
  logic [fss_pkg::NUM_SIGS-1:0]    hit;
  logic [fss_pkg::NUM_SIGS-1:0]    found_now;
  logic [fss_pkg::OFFSET_BITS-1:0] offset_now [fss_pkg::NUM_SIGS];
  logic [fss_pkg::EXT_BITS-1:0]    off_ext    [fss_pkg::NUM_SIGS];
  logic [fss_pkg::RES_BITS-1:0]    res_off    [fss_pkg::NUM_SIGS];

  fss_pkg::res_t                   res_r;
  fss_pkg::res_t                   res_nxt;
  logic                            out_valid_r;
  logic                            out_valid_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign ctl.step    = in_fire && !in_ch.is_last;
  assign ctl.flush   = in_fire && in_ch.is_last;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= fss_pkg::MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  // byte position
  assign pos_sat = pos_r == '1;

  always_comb begin
    pos_nxt = pos_r;
    if (ctl.flush) begin
      pos_nxt = '0;
    end else if (ctl.step && !pos_sat) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // history chain
  for (genvar k = 0; k < fss_pkg::HIST_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      fss_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .data_in  (in_ch.data_byte),
        .live_in  (1'b1),
        .data_out (cell_data[k]),
        .live_out (cell_live[k])
      );
    end else begin : g_body
      fss_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .data_in  (cell_data[k-1]),
        .live_in  (cell_live[k-1]),
        .data_out (cell_data[k]),
        .live_out (cell_live[k])
      );
    end
  end

  // window: oldest byte in the high bits, incoming byte in the low bits
  always_comb begin
    win[fss_pkg::BYTE_BITS-1:0] = in_ch.data_byte;
    for (int k = 0; k < fss_pkg::HIST_LEN; k++) begin
      win[(k+1)*fss_pkg::BYTE_BITS +: fss_pkg::BYTE_BITS] = cell_data[k];
    end
  end

  always_comb begin
    hit_raw[fss_pkg::SIG_LOADER] =
      fss_pkg::sig_hit(win, fss_pkg::PAT_LOADER, fss_pkg::SIG_LEN[fss_pkg::SIG_LOADER]);
    hit_raw[fss_pkg::SIG_KERNEL] =
      fss_pkg::sig_hit(win, fss_pkg::PAT_KERNEL, fss_pkg::SIG_LEN[fss_pkg::SIG_KERNEL]);
    hit_raw[fss_pkg::SIG_SQUASH] =
      fss_pkg::sig_hit(win, fss_pkg::PAT_SQ_A, fss_pkg::SIG_LEN[fss_pkg::SIG_SQUASH]) ||
      fss_pkg::sig_hit(win, fss_pkg::PAT_SQ_B, fss_pkg::SIG_LEN[fss_pkg::SIG_SQUASH]);
    hit_raw[fss_pkg::SIG_FLASHFS] =
      fss_pkg::sig_hit(win, fss_pkg::PAT_FLASHFS, fss_pkg::SIG_LEN[fss_pkg::SIG_FLASHFS]);
  end

  // a hit counts only when its oldest byte lies inside the current image
  for (genvar s = 0; s < fss_pkg::NUM_SIGS; s++) begin : g_sig
    localparam int unsigned OLDEST = int'(fss_pkg::SIG_LEN[s]) - 2;

    assign hit[s] = in_fire && hit_raw[s] && cell_live[OLDEST];

    fss_sig_track u_track (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .hit        (hit[s]),
      .lag        (fss_pkg::SIG_LEN[s] - 1'b1),
      .position   (pos_r),
      .found_now  (found_now[s]),
      .offset_now (offset_now[s])
    );

    assign off_ext[s] = fss_pkg::EXT_BITS'(offset_now[s]);
    assign res_off[s] = found_now[s] && !short_img ?
                        off_ext[s][fss_pkg::RES_BITS-1:0] : '0;
  end

  // length is position + 1; never too small once saturated
  assign short_img = !pos_sat &&
                     (({1'b0, pos_r} + 1'b1) <
                      (fss_pkg::OFFSET_BITS + 1)'(min_len_r));

  always_comb begin
    res_nxt                = res_r;
    res_nxt.too_small      = short_img;
    res_nxt.found          = short_img ? '0 : found_now;
    res_nxt.any_found      = !short_img && (found_now != '0);
    res_nxt.loader_offset  = res_off[fss_pkg::SIG_LOADER];
    res_nxt.kernel_offset  = res_off[fss_pkg::SIG_KERNEL];
    res_nxt.squash_offset  = res_off[fss_pkg::SIG_SQUASH];
    res_nxt.flashfs_offset = res_off[fss_pkg::SIG_FLASHFS];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.flush) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.flush) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.too_small      = res_r.too_small;
  assign out_ch.any_found      = res_r.any_found;
  assign out_ch.loader_found   = res_r.found[fss_pkg::SIG_LOADER];
  assign out_ch.loader_offset  = res_r.loader_offset;
  assign out_ch.kernel_found   = res_r.found[fss_pkg::SIG_KERNEL];
  assign out_ch.kernel_offset  = res_r.kernel_offset;
  assign out_ch.squash_found   = res_r.found[fss_pkg::SIG_SQUASH];
  assign out_ch.squash_offset  = res_r.squash_offset;
  assign out_ch.flashfs_found  = res_r.found[fss_pkg::SIG_FLASHFS];
  assign out_ch.flashfs_offset = res_r.flashfs_offset;

`ifndef NO_ASSERTIONS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.flush |=> out_ch.valid)
    else $error("last word accepted but no result presented");

  a_last_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.flush |=> pos_r == '0)
    else $error("position not cleared after last word");

  a_small_hides_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.too_small |-> res_r.found == '0 && !res_r.any_found)
    else $error("too-small image reports a signature");

  a_any_found_or: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.any_found == (res_r.found != '0))
    else $error("any_found disagrees with found flags");
`endif

endmodule
